FILE: hdl/aes_pkg.sv
package aes_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [127:0] block_t;

  localparam int RoundCount = 10;
  localparam int KeyWords = 22;
  localparam int KeyAddrW = 5;
  localparam logic [KeyAddrW-1:0] KeyLastAddr = 5'd21;

  localparam logic [0:0] CFG_KEY_HIGH = 1'b0;
  localparam logic [0:0] CFG_KEY_LOW = 1'b1;

  localparam byte_t SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam byte_t RCON [RoundCount] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // Multiply by x in GF(2^8).
  function automatic byte_t xtime(input byte_t a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Substitute the four bytes of a word.
  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // One cipher round without the key addition; byte 0 sits in bits 127:120.
  function automatic block_t round_fn(input block_t s, input logic mix);
    byte_t b [16];
    byte_t t [16];
    byte_t a0, a1, a2, a3, all;
    block_t o;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) t[r+4*c] = SBOX[b[r+4*((c+r)%4)]];
    end
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
    round_fn = o;
  endfunction

endpackage

FILE: hdl/aes_ram.sv
module aes_ram #(
  parameter int Width = 64,
  parameter int Depth = 22,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/aes_key_expand.sv
module aes_key_expand import aes_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [63:0]         key_high,
  input  logic [63:0]         key_low,
  output logic                busy,
  output logic                we,
  output logic [KeyAddrW-1:0] waddr,
  output logic [63:0]         wdata
);

  logic [127:0] w_r, w_nxt;
  logic [KeyAddrW-1:0] addr_r, addr_nxt;
  logic busy_r, busy_nxt;
  logic [3:0] rnd_r, rnd_nxt;
  logic [31:0] t, w0, w1, w2, w3;

  // Next round key from the current one.
  always_comb begin
    t = sub_word({w_r[23:0], w_r[31:24]}) ^ {RCON[rnd_r], 24'h0};
    w0 = w_r[127:96] ^ t;
    w1 = w_r[95:64] ^ w0;
    w2 = w_r[63:32] ^ w1;
    w3 = w_r[31:0] ^ w2;
  end

  // Write one word a cycle: high half, then low half, then advance a round.
  always_comb begin
    w_nxt = w_r;
    addr_nxt = addr_r;
    busy_nxt = busy_r;
    rnd_nxt = rnd_r;
    if (start) begin
      w_nxt = {key_high, key_low};
      addr_nxt = '0;
      busy_nxt = 1'b1;
      rnd_nxt = '0;
    end else if (busy_r) begin
      addr_nxt = addr_r + 1'b1;
      if (addr_r == KeyLastAddr) begin
        busy_nxt = 1'b0;
      end
      if (addr_r[0]) begin
        w_nxt = {w0, w1, w2, w3};
        rnd_nxt = rnd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      addr_r <= '0;
      rnd_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      addr_r <= addr_nxt;
      rnd_r <= rnd_nxt;
    end
    w_r <= w_nxt;
  end

  assign busy = busy_r;
  assign we = busy_r;
  assign waddr = addr_r;
  assign wdata = addr_r[0] ? w_r[63:0] : w_r[127:64];

endmodule

FILE: hdl/aes128_block_encrypt_unit.sv
// AES-128 encryption engine. The key is written as two 64-bit words
// (index 0 = key bytes 0..7, index 1 = bytes 8..15); each write, and reset,
// starts a key expansion into a round key RAM, during which no request is
// accepted. The round key RAM has one 64-bit read port, so each of the
// eleven 128-bit round keys is fetched in two reads; the first key is added
// to the plaintext and the round unit applies one round per later key.
// Requests are handled one at a time; a finished result waits in the output
// register and the next request is taken as soon as it leaves.
module aes128_block_encrypt_unit import aes_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_plain_high,
  input  logic [63:0] in_plain_low,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_cipher_high,
  output logic [63:0] out_cipher_low,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;

  logic [63:0] key_high_r, key_low_r;
  logic init_r;
  logic kx_busy, kx_we;
  logic [KeyAddrW-1:0] kx_waddr, raddr;
  logic [63:0] kx_wdata, rdata;
  logic [1:0] st_r, st_nxt;
  logic [KeyAddrW-1:0] rd_r, rd_nxt;
  logic [KeyAddrW-1:0] use_r, use_nxt;
  logic use_v_r, use_v_nxt;
  logic [63:0] khi_r, khi_nxt;
  block_t s_r, s_nxt, plain_r, plain_nxt;
  logic ov_r, ov_nxt;
  block_t res_r, res_nxt;
  logic start;
  block_t key, rnd;

  // Key registers; an out-of-range index cannot occur with a one-bit index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r <= '0;
      init_r <= 1'b1;
    end else begin
      init_r <= 1'b0;
      if (cfg_we && cfg_index == CFG_KEY_HIGH) key_high_r <= cfg_wdata;
      if (cfg_we && cfg_index == CFG_KEY_LOW) key_low_r <= cfg_wdata;
    end
  end

  assign start = init_r || cfg_we;

  aes_key_expand u_kx (
    .clk(clk), .rst_n(rst_n), .start(start),
    .key_high(cfg_we && cfg_index == CFG_KEY_HIGH ? cfg_wdata : key_high_r),
    .key_low(cfg_we && cfg_index == CFG_KEY_LOW ? cfg_wdata : key_low_r),
    .busy(kx_busy), .we(kx_we), .waddr(kx_waddr), .wdata(kx_wdata)
  );

  aes_ram #(.Width(64), .Depth(KeyWords), .AddrW(KeyAddrW)) u_rk (
    .clk(clk), .we(kx_we), .waddr(kx_waddr), .wdata(kx_wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign in_ready = (st_r == ST_IDLE) && !kx_busy && !start && !ov_r;
  assign raddr = rd_r;
  assign key = {khi_r, rdata};
  assign rnd = round_fn(s_r, use_r != KeyLastAddr);

  // Round sequencer: read key words in order, latch each high word and apply a round on each low word after the first.
  always_comb begin
    st_nxt = st_r;
    rd_nxt = rd_r;
    use_nxt = use_r;
    use_v_nxt = 1'b0;
    khi_nxt = khi_r;
    s_nxt = s_r;
    plain_nxt = plain_r;
    ov_nxt = ov_r;
    res_nxt = res_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          plain_nxt = {in_plain_high, in_plain_low};
          st_nxt = ST_RUN;
          rd_nxt = '0;
        end
      end
      ST_RUN: begin
        if (rd_r != KeyLastAddr + 1'b1) begin
          use_nxt = rd_r;
          use_v_nxt = 1'b1;
          rd_nxt = rd_r + 1'b1;
        end
        if (use_v_r) begin
          if (!use_r[0]) begin
            khi_nxt = rdata;
          end else if (use_r == 5'd1) begin
            s_nxt = plain_r ^ key;
          end else if (use_r == KeyLastAddr) begin
            res_nxt = rnd ^ key;
            ov_nxt = 1'b1;
            st_nxt = ST_IDLE;
          end else begin
            s_nxt = rnd ^ key;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      rd_r <= '0;
      use_r <= '0;
      use_v_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      rd_r <= rd_nxt;
      use_r <= use_nxt;
      use_v_r <= use_v_nxt;
      ov_r <= ov_nxt;
    end
    khi_r <= khi_nxt;
    s_r <= s_nxt;
    plain_r <= plain_nxt;
    res_r <= res_nxt;
  end

  assign out_valid = ov_r;
  assign out_cipher_high = res_r[127:64];
  assign out_cipher_low = res_r[63:0];

endmodule

FILE: test/tb_aes128_block_encrypt_unit.sv
module tb_aes128_block_encrypt_unit;
  import aes_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 5000;
  localparam int SettleCycles = 60;
  localparam int RandomBlocks = 700;

  // Keeps the expected ciphertexts and a private key schedule.
  class cipher_scoreboard;
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [63:0] sched [22];
    logic [127:0] pending_cipher [$];
    int errors;

    function new();
      key_hi = '0;
      key_lo = '0;
      errors = 0;
      expand();
    endfunction

    function logic [7:0] sub_byte(logic [7:0] a);
      return SBOX[a];
    endfunction

    function logic [7:0] mul2(logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Standard AES-128 key expansion from the current key words.
    function void expand();
      logic [31:0] w [4];
      logic [31:0] t;
      w[0] = key_hi[63:32]; w[1] = key_hi[31:0];
      w[2] = key_lo[63:32]; w[3] = key_lo[31:0];
      sched[0] = key_hi;
      sched[1] = key_lo;
      for (int r = 1; r <= 10; r++) begin
        t = {w[3][23:0], w[3][31:24]};
        t = {sub_byte(t[31:24]), sub_byte(t[23:16]), sub_byte(t[15:8]), sub_byte(t[7:0])};
        t ^= {RCON[r-1], 24'h0};
        w[0] ^= t; w[1] ^= w[0]; w[2] ^= w[1]; w[3] ^= w[2];
        sched[2*r] = {w[0], w[1]};
        sched[2*r+1] = {w[2], w[3]};
      end
    endfunction

    function void write_key(logic [0:0] idx, logic [63:0] val);
      if (idx == CFG_KEY_HIGH) key_hi = val;
      else key_lo = val;
      expand();
    endfunction

    function logic [127:0] encrypt(logic [127:0] plain);
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, x;
      logic [127:0] rk;
      logic [127:0] res;
      for (int i = 0; i < 16; i++) s[i] = plain[127-8*i -: 8];
      for (int r = 0; r <= 10; r++) begin
        if (r > 0) begin
          for (int c = 0; c < 4; c++)
            for (int j = 0; j < 4; j++) t[j+4*c] = sub_byte(s[j+4*((c+j)&3)]);
          if (r < 10) begin
            for (int c = 0; c < 4; c++) begin
              a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
              x = a0 ^ a1 ^ a2 ^ a3;
              t[4*c] = a0 ^ x ^ mul2(a0 ^ a1);
              t[4*c+1] = a1 ^ x ^ mul2(a1 ^ a2);
              t[4*c+2] = a2 ^ x ^ mul2(a2 ^ a3);
              t[4*c+3] = a3 ^ x ^ mul2(a3 ^ a0);
            end
          end
          s = t;
        end
        rk = {sched[2*r], sched[2*r+1]};
        for (int i = 0; i < 16; i++) s[i] ^= rk[127-8*i -: 8];
      end
      for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
      return res;
    endfunction

    function void note_plain(logic [63:0] hi, logic [63:0] lo);
      pending_cipher.push_back(encrypt({hi, lo}));
    endfunction

    function void check_cipher(logic [63:0] hi, logic [63:0] lo);
      logic [127:0] want;
      if (pending_cipher.size() == 0) begin
        $error("unexpected result %h %h", hi, lo);
        errors++;
        return;
      end
      want = pending_cipher.pop_front();
      if (want[127:64] !== hi) begin
        $error("cipher_high expected %h actual %h", want[127:64], hi);
        errors++;
      end
      if (want[63:0] !== lo) begin
        $error("cipher_low expected %h actual %h", want[63:0], lo);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [63:0] in_plain_high = '0;
  logic [63:0] in_plain_low = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [63:0] out_cipher_high;
  logic [63:0] out_cipher_low;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  cipher_scoreboard sb;
  bit idle_enable = 1'b1;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  aes128_block_encrypt_unit i_dut (.*);

  // Check every accepted result and watch for a stuck block.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_cipher(out_cipher_high, out_cipher_low);
      if ((out_valid && out_ready) || (in_valid && in_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Result side stalls in random bursts.
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      if (idle_enable && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 18);
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // The enable drops for one cycle so that writes never share a time step.
  task automatic write_key_word(logic [0:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sb.write_key(idx, val);
  endtask

  // Wait for the block to drain before touching the key.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_cipher.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Valid stays high into the next request unless an idle burst comes first.
  task automatic send_block(logic [63:0] hi, logic [63:0] lo);
    int gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_plain_high <= hi;
    in_plain_low <= lo;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_plain(hi, lo);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 64'h1 << $urandom_range(0, 63);
      default: return rand64();
    endcase
  endfunction

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero key, extreme blocks, then the FIPS-197 example key.
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h8000_0000_0000_0000, 64'h1);
    send_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
    drain();
    write_key_word(CFG_KEY_HIGH, 64'h0001_0203_0405_0607);
    write_key_word(CFG_KEY_LOW, 64'h0809_0a0b_0c0d_0e0f);
    send_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
    send_block('0, '1);
    drain();
    // All-ones key.
    write_key_word(CFG_KEY_HIGH, '1);
    write_key_word(CFG_KEY_LOW, '1);
    send_block('0, '0);
    send_block('1, '1);
    drain();
    // Partial key update: blocks between the two halves.
    write_key_word(CFG_KEY_HIGH, 64'h2b7e_1516_28ae_d2a6);
    send_block(64'h3243_f6a8_885a_308d, 64'h3132_9876_5432_10ff);
    drain();
    write_key_word(CFG_KEY_LOW, 64'habf7_1588_09cf_4f3c);
    send_block(64'h3243_f6a8_885a_308d, 64'h3132_9876_5432_10ff);
    send_block(rand64(), rand64());
    drain();

    // Random phases with new keys in between.
    for (int n = 0; n < RandomBlocks; n++) begin
      if (n == RandomBlocks - 100) idle_enable = 1'b0;
      if (n % 50 == 0) begin
        drain();
        if ($urandom_range(0, 1)) write_key_word(CFG_KEY_HIGH, pick_word());
        write_key_word(CFG_KEY_LOW, pick_word());
        if ($urandom_range(0, 1)) write_key_word(CFG_KEY_HIGH, pick_word());
      end
      send_block(pick_word(), pick_word());
    end

    drain();
    if (sb.errors == 0 && sb.pending_cipher.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

FILE: filelist.f
hdl/aes_pkg.sv
hdl/aes_ram.sv
hdl/aes_key_expand.sv
hdl/aes128_block_encrypt_unit.sv
test/tb_aes128_block_encrypt_unit.sv
